### hw/rtl/range_set_merge_table_assert.svh
`ifndef RANGE_SET_MERGE_TABLE_ASSERT_SVH
`define RANGE_SET_MERGE_TABLE_ASSERT_SVH

// check a condition in the same cycle
`define RSMT_ASSERT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("range table check failed");

// check a condition in the cycle after
`define RSMT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("range table check failed");

`endif

### hw/rtl/rsmt_pkg.sv
package rsmt_pkg;

    localparam int MAX_RANGES = 16;
    localparam int POS_WIDTH  = 24;
    localparam int IDX_WIDTH  = 8;

    localparam logic [2:0] OP_SET    = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_INVERT = 3'd4;
    localparam logic [2:0] OP_EDIT   = 3'd5;
    localparam logic [2:0] OP_EXTEND = 3'd6;

    typedef struct packed {
        logic capture;
        logic apply_simple;
        logic sort_init;
        logic sort_step;
        logic walk_init;
        logic walk_step;
        logic walk_finish;
        logic dump_init;
        logic load_out;
    } rsmt_cmd_t;

    typedef struct packed {
        logic need_sort;
        logic is_edit;
        logic sort_done;
        logic walk_done;
        logic dump_last;
        logic out_free;
    } rsmt_stat_t;

endpackage

### hw/rtl/range_set_merge_table.sv
// Set, clear, remove, extend, add of an empty range and invert of an empty table go from the
// execute state straight to the output; add and invert otherwise run a serial insert sort and
// then one walk step per entry, and edit shift runs the walk alone, without the sort.
// Then max(N,1) beats go out for N resulting entries, one per cycle while m_ready is high.
// One operation at a time; the next item is taken once the last beat is loaded.
// Reset (aresetn low, synchronous) empties the table and drops any pending beat.
module range_set_merge_table #(
    parameter int MAX_RANGES = rsmt_pkg::MAX_RANGES,
    parameter int POS_WIDTH  = rsmt_pkg::POS_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_opcode,
    input  logic [POS_WIDTH-1:0]          s_range_start,
    input  logic [POS_WIDTH-1:0]          s_range_end,
    input  logic [rsmt_pkg::IDX_WIDTH-1:0] s_entry_index,
    input  logic [POS_WIDTH-1:0]          s_text_length,
    input  logic [POS_WIDTH-1:0]          s_position,
    input  logic [POS_WIDTH-1:0]          s_removed_length,
    input  logic [POS_WIDTH-1:0]          s_inserted_length,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [POS_WIDTH-1:0]          m_entry_start,
    output logic [POS_WIDTH-1:0]          m_entry_end,
    output logic                          m_entry_valid,
    output logic                          m_last_entry,
    output logic                          m_overflowed
);

    rsmt_pkg::rsmt_cmd_t  cmd;
    rsmt_pkg::rsmt_stat_t stat;

    rsmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rsmt_dpath #(
        .MAX_RANGES (MAX_RANGES),
        .POS_WIDTH  (POS_WIDTH)
    ) u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_opcode          (s_opcode),
        .s_range_start     (s_range_start),
        .s_range_end       (s_range_end),
        .s_entry_index     (s_entry_index),
        .s_text_length     (s_text_length),
        .s_position        (s_position),
        .s_removed_length  (s_removed_length),
        .s_inserted_length (s_inserted_length),
        .m_entry_start     (m_entry_start),
        .m_entry_end       (m_entry_end),
        .m_entry_valid     (m_entry_valid),
        .m_last_entry      (m_last_entry),
        .m_overflowed      (m_overflowed),
        .m_valid           (m_valid),
        .m_ready           (m_ready)
    );

endmodule

### hw/rtl/rsmt_ctrl.sv
module rsmt_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rsmt_pkg::rsmt_stat_t stat,
    output rsmt_pkg::rsmt_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_SORT = 5'b00100,
        ST_WALK = 5'b01000,
        ST_DUMP = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.need_sort) begin
                    cmd.sort_init = 1'b1;
                    state_next    = ST_SORT;
                end else if (stat.is_edit) begin
                    cmd.walk_init = 1'b1;
                    state_next    = ST_WALK;
                end else begin
                    cmd.apply_simple = 1'b1;
                    cmd.dump_init    = 1'b1;
                    state_next       = ST_DUMP;
                end
            end
            ST_SORT: begin
                if (stat.sort_done) begin
                    cmd.walk_init = 1'b1;
                    state_next    = ST_WALK;
                end else begin
                    cmd.sort_step = 1'b1;
                end
            end
            ST_WALK: begin
                if (stat.walk_done) begin
                    cmd.walk_finish = 1'b1;
                    cmd.dump_init   = 1'b1;
                    state_next      = ST_DUMP;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_DUMP: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    if (stat.dump_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/rsmt_dpath.sv
`include "range_set_merge_table_assert.svh"

module rsmt_dpath #(
    parameter int MAX_RANGES = rsmt_pkg::MAX_RANGES,
    parameter int POS_WIDTH  = rsmt_pkg::POS_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rsmt_pkg::rsmt_cmd_t           cmd,
    output rsmt_pkg::rsmt_stat_t          stat,
    input  logic [2:0]                    s_opcode,
    input  logic [POS_WIDTH-1:0]          s_range_start,
    input  logic [POS_WIDTH-1:0]          s_range_end,
    input  logic [rsmt_pkg::IDX_WIDTH-1:0] s_entry_index,
    input  logic [POS_WIDTH-1:0]          s_text_length,
    input  logic [POS_WIDTH-1:0]          s_position,
    input  logic [POS_WIDTH-1:0]          s_removed_length,
    input  logic [POS_WIDTH-1:0]          s_inserted_length,
    output logic [POS_WIDTH-1:0]          m_entry_start,
    output logic [POS_WIDTH-1:0]          m_entry_end,
    output logic                          m_entry_valid,
    output logic                          m_last_entry,
    output logic                          m_overflowed,
    output logic                          m_valid,
    input  logic                          m_ready
);

    localparam int W   = POS_WIDTH;
    localparam int XW  = POS_WIDTH + 2;
    localparam int NS  = MAX_RANGES + 1;
    localparam int CW  = $clog2(MAX_RANGES + 2);
    localparam int TIW = $clog2(MAX_RANGES);
    localparam int SIW = $clog2(MAX_RANGES + 1);
    localparam int IW  = rsmt_pkg::IDX_WIDTH;

    logic [W-1:0]  tab_s_reg [MAX_RANGES];
    logic [W-1:0]  tab_e_reg [MAX_RANGES];
    logic [CW-1:0] cnt_reg;

    logic [2:0]    op_reg;
    logic [W-1:0]  a_reg, b_reg, tlen_reg, pos_reg;
    logic [IW-1:0] idx_reg;
    logic signed [XW-1:0] net_reg, prem_reg, pins_reg;

    logic [W-1:0]  srt_s_reg [NS];
    logic [W-1:0]  srt_e_reg [NS];
    logic [W-1:0]  srt_s_next [NS];
    logic [W-1:0]  srt_e_next [NS];
    logic [CW-1:0] srt_n_reg;
    logic          gt [NS];

    logic [CW-1:0] k_reg, m_reg;
    logic          have_reg, have_next;
    logic [W-1:0]  cur_s_reg, cur_s_next, cur_e_reg, cur_e_next;
    logic          ovf_reg;

    logic [W-1:0]  out_s_reg, out_e_reg;
    logic          out_v_reg, out_last_reg, out_ovf_reg, mvalid_reg;

    logic [TIW-1:0] k_t;
    logic [SIW-1:0] k_s;
    logic [W-1:0]  key_s, key_e, ws, we;
    logic [CW-1:0] sort_total, walk_total, m_fin;
    logic          wr_en;
    logic [W-1:0]  wr_s, wr_e;
    logic          out_free;

    logic signed [XW-1:0] xs, xe, xp, xs1, xe1, xs2, xe2, xmax;
    logic [W-1:0]  ed_s, ed_e;

    assign k_t = k_reg[TIW-1:0];
    assign k_s = k_reg[SIW-1:0];

    assign out_free   = !mvalid_reg || m_ready;
    assign sort_total = (op_reg == rsmt_pkg::OP_ADD) ? cnt_reg + CW'(1) : cnt_reg;
    assign walk_total = (op_reg == rsmt_pkg::OP_EDIT) ? cnt_reg : srt_n_reg;

    always_comb begin
        stat.need_sort = ((op_reg == rsmt_pkg::OP_ADD) && (a_reg != b_reg)) ||
                         ((op_reg == rsmt_pkg::OP_INVERT) && (cnt_reg != '0));
        stat.is_edit   = (op_reg == rsmt_pkg::OP_EDIT);
        stat.sort_done = (k_reg == sort_total);
        stat.walk_done = (k_reg == walk_total);
        stat.dump_last = (cnt_reg == '0) || (k_reg == cnt_reg - CW'(1));
        stat.out_free  = out_free;
    end

    always_comb begin
        if (k_reg == cnt_reg) begin
            key_s = a_reg;
            key_e = b_reg;
        end else begin
            key_s = tab_s_reg[k_t];
            key_e = tab_e_reg[k_t];
        end
        for (int i = 0; i < NS; i++) begin
            gt[i] = (CW'(i) < srt_n_reg) && (srt_s_reg[i] > key_s);
        end
        for (int i = 0; i < NS; i++) begin
            srt_s_next[i] = srt_s_reg[i];
            srt_e_next[i] = srt_e_reg[i];
            if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
                srt_s_next[i] = srt_s_reg[(i > 0) ? i - 1 : 0];
                srt_e_next[i] = srt_e_reg[(i > 0) ? i - 1 : 0];
            end else if ((CW'(i) == srt_n_reg) || gt[i]) begin
                srt_s_next[i] = key_s;
                srt_e_next[i] = key_e;
            end
        end
    end

    always_comb begin
        if (op_reg == rsmt_pkg::OP_EDIT) begin
            ws = tab_s_reg[k_t];
            we = tab_e_reg[k_t];
        end else begin
            ws = srt_s_reg[k_s];
            we = srt_e_reg[k_s];
        end
    end

    always_comb begin
        xmax = {2'b00, {W{1'b1}}};
        xs   = {2'b00, ws};
        xe   = {2'b00, we};
        xp   = {2'b00, pos_reg};
        xs1  = xs;
        xe1  = xe;
        if (xp <= xs) begin
            xs1 = xs + net_reg;
            xe1 = xe + net_reg;
        end else if (xp < xe) begin
            xe1 = (prem_reg <= xe) ? xe + net_reg : pins_reg;
        end
        xs2 = (xs1 < 0) ? '0 : xs1;
        xe2 = (xe1 < xs2) ? xs2 : xe1;
        xs2 = (xs2 > xmax) ? xmax : xs2;
        xe2 = (xe2 > xmax) ? xmax : xe2;
        ed_s = xs2[W-1:0];
        ed_e = xe2[W-1:0];
    end

    always_comb begin
        wr_en      = 1'b0;
        wr_s       = cur_s_reg;
        wr_e       = cur_e_reg;
        cur_s_next = cur_s_reg;
        cur_e_next = cur_e_reg;
        have_next  = have_reg;
        if (cmd.walk_step) begin
            case (op_reg)
                rsmt_pkg::OP_ADD: begin
                    if (have_reg && ws <= cur_e_reg) begin
                        if (we > cur_e_reg) begin
                            cur_e_next = we;
                        end
                    end else begin
                        wr_en      = have_reg;
                        cur_s_next = ws;
                        cur_e_next = we;
                        have_next  = 1'b1;
                    end
                end
                rsmt_pkg::OP_INVERT: begin
                    if (cur_e_reg < ws) begin
                        wr_en = 1'b1;
                        wr_s  = cur_e_reg;
                        wr_e  = ws;
                    end
                    cur_e_next = we;
                end
                rsmt_pkg::OP_EDIT: begin
                    wr_en = (ed_s != ed_e);
                    wr_s  = ed_s;
                    wr_e  = ed_e;
                end
                default: ;
            endcase
        end else if (cmd.walk_finish) begin
            case (op_reg)
                rsmt_pkg::OP_ADD: wr_en = have_reg;
                rsmt_pkg::OP_INVERT: begin
                    if (cur_e_reg < tlen_reg) begin
                        wr_en = 1'b1;
                        wr_s  = cur_e_reg;
                        wr_e  = tlen_reg;
                    end
                end
                default: ;
            endcase
        end
        m_fin = m_reg + CW'(wr_en);
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= s_opcode;
            a_reg    <= (s_range_start > s_range_end) ? s_range_end : s_range_start;
            b_reg    <= (s_range_start > s_range_end) ? s_range_start : s_range_end;
            idx_reg  <= s_entry_index;
            tlen_reg <= s_text_length;
            pos_reg  <= s_position;
            net_reg  <= {2'b00, s_inserted_length} - {2'b00, s_removed_length};
            prem_reg <= {2'b00, s_position} + {2'b00, s_removed_length};
            pins_reg <= {2'b00, s_position} + {2'b00, s_inserted_length};
        end
        if (cmd.sort_step) begin
            for (int i = 0; i < NS; i++) begin
                srt_s_reg[i] <= srt_s_next[i];
                srt_e_reg[i] <= srt_e_next[i];
            end
        end
        if (cmd.walk_init) begin
            cur_s_reg <= '0;
            cur_e_reg <= '0;
        end else begin
            cur_s_reg <= cur_s_next;
            cur_e_reg <= cur_e_next;
        end
        if (wr_en && (m_reg < CW'(MAX_RANGES))) begin
            tab_s_reg[m_reg[TIW-1:0]] <= wr_s;
            tab_e_reg[m_reg[TIW-1:0]] <= wr_e;
        end
        if (cmd.apply_simple) begin
            case (op_reg)
                rsmt_pkg::OP_SET: begin
                    tab_s_reg[0] <= a_reg;
                    tab_e_reg[0] <= b_reg;
                end
                rsmt_pkg::OP_REMOVE: begin
                    for (int i = 0; i + 1 < MAX_RANGES; i++) begin
                        if (IW'(i) >= idx_reg) begin
                            tab_s_reg[i] <= tab_s_reg[i + 1];
                            tab_e_reg[i] <= tab_e_reg[i + 1];
                        end
                    end
                end
                rsmt_pkg::OP_INVERT: begin
                    tab_s_reg[0] <= '0;
                    tab_e_reg[0] <= tlen_reg;
                end
                rsmt_pkg::OP_EXTEND: begin
                    if (pos_reg < tab_s_reg[0]) begin
                        tab_s_reg[0] <= pos_reg;
                    end else if (pos_reg > tab_e_reg[0]) begin
                        tab_e_reg[0] <= pos_reg;
                    end else if ((pos_reg - tab_s_reg[0]) < (tab_e_reg[0] - pos_reg)) begin
                        tab_s_reg[0] <= pos_reg;
                    end else begin
                        tab_e_reg[0] <= pos_reg;
                    end
                end
                default: ;
            endcase
        end
        if (cmd.load_out) begin
            out_ovf_reg <= ovf_reg;
            if (cnt_reg == '0) begin
                out_s_reg    <= '0;
                out_e_reg    <= '0;
                out_v_reg    <= 1'b0;
                out_last_reg <= 1'b1;
            end else begin
                out_s_reg    <= tab_s_reg[k_t];
                out_e_reg    <= tab_e_reg[k_t];
                out_v_reg    <= 1'b1;
                out_last_reg <= (k_reg == cnt_reg - CW'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            srt_n_reg  <= '0;
            k_reg      <= '0;
            m_reg      <= '0;
            have_reg   <= 1'b0;
            ovf_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            if (cmd.capture) begin
                ovf_reg <= 1'b0;
            end else if (wr_en && (m_reg >= CW'(MAX_RANGES))) begin
                ovf_reg <= 1'b1;
            end
            if (cmd.sort_init) begin
                k_reg     <= '0;
                srt_n_reg <= '0;
            end else if (cmd.sort_step) begin
                k_reg     <= k_reg + CW'(1);
                srt_n_reg <= srt_n_reg + CW'(1);
            end else if (cmd.walk_init || cmd.dump_init) begin
                k_reg <= '0;
            end else if (cmd.walk_step || cmd.load_out) begin
                k_reg <= k_reg + CW'(1);
            end
            if (cmd.walk_init) begin
                m_reg    <= '0;
                have_reg <= 1'b0;
            end else begin
                m_reg    <= wr_en ? m_fin : m_reg;
                have_reg <= have_next;
            end
            if (cmd.walk_finish) begin
                cnt_reg <= (m_fin > CW'(MAX_RANGES)) ? CW'(MAX_RANGES) : m_fin;
            end else if (cmd.apply_simple) begin
                case (op_reg)
                    rsmt_pkg::OP_SET: cnt_reg <= (a_reg == b_reg) ? '0 : CW'(1);
                    rsmt_pkg::OP_CLEAR: cnt_reg <= '0;
                    rsmt_pkg::OP_REMOVE: begin
                        if (idx_reg < IW'(cnt_reg)) begin
                            cnt_reg <= cnt_reg - CW'(1);
                        end
                    end
                    rsmt_pkg::OP_INVERT: begin
                        if (cnt_reg == '0 && tlen_reg != '0) begin
                            cnt_reg <= CW'(1);
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.load_out) begin
                mvalid_reg <= 1'b1;
            end else if (m_ready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    assign m_entry_start = out_s_reg;
    assign m_entry_end   = out_e_reg;
    assign m_entry_valid = out_v_reg;
    assign m_last_entry  = out_last_reg;
    assign m_overflowed  = out_ovf_reg;
    assign m_valid       = mvalid_reg;

    `RSMT_ASSERT(a_cnt_bound, 1'b1, cnt_reg <= CW'(MAX_RANGES))
    `RSMT_ASSERT(a_load_free, cmd.load_out, out_free)
    `RSMT_ASSERT(a_sorted_head, srt_n_reg >= CW'(2), srt_s_reg[0] <= srt_s_reg[1])
    `RSMT_ASSERT_NEXT(a_beat_loaded, cmd.load_out, mvalid_reg)

endmodule
